### src/tti_pkg.sv
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types, character codes and limits for the text to integer parser.
// ----------------------------------------------------------------------------
package tti_pkg;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int END_W    = 16;
    localparam int BASE_W   = 6;
    localparam int DIGIT_W  = 6;
    localparam int PROD_W   = VALUE_W + BASE_W;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_FIRST,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        DS_NONE,
        DS_OK,
        DS_OVER
    } t_digit_state;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCTAL = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

    // digit value of anything that is not alphanumeric, above every legal base
    localparam logic [DIGIT_W-1:0] DIGIT_NONE = '1;
    localparam logic [CHAR_W-1:0]  LETTER_OFS = 8'd10;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

    // magnitude limits for positive and negative results
    localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_in_beat;

    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [DIGIT_W-1:0] digit;
        logic [VALUE_W-1:0] acc;
        logic               neg;
        logic               over;
    } t_mac_req;

    typedef struct packed {
        logic               stop;
        logic               over;
        logic [VALUE_W-1:0] acc;
    } t_mac_res;

    function automatic logic f_is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic f_is_hex(input logic [CHAR_W-1:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF)) ||
               ((c >= CH_LA) && (c <= CH_LF));
    endfunction

    function automatic logic [DIGIT_W-1:0] f_char_value(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] v;
        v = DIGIT_NONE;
        if ((c >= CH_0) && (c <= CH_9)) begin
            v = DIGIT_W'(c - CH_0);
        end else if ((c >= CH_UA) && (c <= CH_UZ)) begin
            v = DIGIT_W'(c - CH_UA + LETTER_OFS);
        end else if ((c >= CH_LA) && (c <= CH_LZ)) begin
            v = DIGIT_W'(c - CH_LA + LETTER_OFS);
        end
        return v;
    endfunction

endpackage

### src/text_to_signed_integer_core.sv
// ----------------------------------------------------------------------------
// text_to_signed_integer_core
// Streaming strtol-style parser of a text string into a signed 32-bit value.
// ----------------------------------------------------------------------------
// One character beat is taken per clock unless a last beat waits for the
// result register, with no gaps between strings. A beat lands in the input
// register, from which the parse state is updated by one multiply-add of the
// accumulator by the active base plus a limit compare; that single step per
// character sets the rate. The beat marked last behaves as if a NUL followed
// it and produces one result beat, written to the result register when the
// parser takes that character and held there while the result side stalls.
// The input side keeps accepting while a finished result waits; only a
// further last beat waits for the result register to drain. number_base is
// sampled at the first character after the optional sign, so a write
// affects the next string. There is no clearing pass after reset. Status:
// 0 ok, 1 saturated out of range, 2 invalid or no digits (value 0, end
// index 0). The end index saturates at MAX_POSITION and its low 16 bits
// are shown.
// ----------------------------------------------------------------------------
module text_to_signed_integer_core
    import tti_pkg::*;
#(
    parameter longint unsigned MAX_POSITION = 65535
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    // character beats
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [CHAR_W-1:0]         i_character,
    input  logic                      i_last,

    // result beats
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [STATUS_W-1:0]       o_status,
    output logic [END_W-1:0]          o_end_index,

    // number base register write
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [BASE_W-1:0]         i_cfg_number_base
);

    logic [BASE_W-1:0] r_number_base;
    t_in_beat          beat;
    logic              take;

    // config register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_number_base <= i_cfg_number_base;
        end
    end

    // input register
    tti_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_character (i_character),
        .i_last      (i_last),
        .i_take      (take),
        .o_beat      (beat)
    );

    // parse step and result register
    tti_parser #(
        .MAX_POSITION (MAX_POSITION)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat        (beat),
        .o_take        (take),
        .i_number_base (r_number_base),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value),
        .o_status      (o_status),
        .o_end_index   (o_end_index)
    );

endmodule

### src/tti_in_stage.sv
// ----------------------------------------------------------------------------
// tti_in_stage
// Input register: holds one character beat until the parser consumes it.
// ----------------------------------------------------------------------------
module tti_in_stage
    import tti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CHAR_W-1:0] i_character,
    input  logic              i_last,
    input  logic              i_take,
    output t_in_beat          o_beat
);

    logic              r_valid;
    logic [CHAR_W-1:0] r_character;
    logic              r_last;

    // free, or emptied by the parser in this cycle
    assign o_in_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_character <= i_character;
            r_last      <= i_last;
        end
    end

    assign o_beat.valid     = r_valid;
    assign o_beat.character = r_character;
    assign o_beat.last      = r_last;

endmodule

### src/tti_digit_acc.sv
// ----------------------------------------------------------------------------
// tti_digit_acc
// One digit step: accumulator times base plus digit, with saturation check.
// ----------------------------------------------------------------------------
module tti_digit_acc
    import tti_pkg::*;
(
    input  t_mac_req i_req,
    output t_mac_res o_res
);

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] sum;
    logic [PROD_W-1:0] limit;
    logic              over;

    always_comb begin
        prod  = PROD_W'(i_req.acc) * PROD_W'(i_req.base);
        sum   = prod + PROD_W'(i_req.digit);
        limit = i_req.neg ? PROD_W'(NEG_LIMIT) : PROD_W'(POS_LIMIT);
        // once saturated the accumulator is frozen
        over  = i_req.over || (sum > limit);

        o_res.stop = (i_req.digit >= i_req.base);
        o_res.over = over;
        o_res.acc  = over ? i_req.acc : sum[VALUE_W-1:0];
    end

endmodule

### src/tti_parser.sv
// ----------------------------------------------------------------------------
// tti_parser
// Parse state, per-character update and the result register.
// ----------------------------------------------------------------------------
module tti_parser
    import tti_pkg::*;
#(
    parameter longint unsigned MAX_POSITION = 65535
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_in_beat                  i_beat,
    output logic                      o_take,
    input  logic [BASE_W-1:0]         i_number_base,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [STATUS_W-1:0]       o_status,
    output logic [END_W-1:0]          o_end_index
);

    localparam int              POS_W   = $clog2(MAX_POSITION + 64'd1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_POSITION);

    // parse state
    t_phase             r_phase,  n_phase;
    logic [VALUE_W-1:0] r_acc,    n_acc;
    logic               r_neg,    n_neg;
    t_digit_state       r_ds,     n_ds;
    logic [BASE_W-1:0]  r_base,   n_base;
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [POS_W-1:0]   r_stop,   n_stop;

    // result register
    logic               r_out_valid;
    t_digit_state       r_res_ds;
    logic               r_res_neg;
    logic [VALUE_W-1:0] r_res_acc;
    logic [POS_W-1:0]   r_res_stop;

    logic               take;
    logic               finish;
    logic [CHAR_W-1:0]  ch;
    logic               ch_space;
    logic               ch_hex;
    logic               ch_x;
    logic               ch_sign;
    logic [DIGIT_W-1:0] ch_digit;
    logic               first_zero;
    logic               first_bad;
    logic [BASE_W-1:0]  first_base;
    logic [BASE_W-1:0]  zero_base;
    t_phase             first_phase;
    logic               take_first;
    logic               take_digit;
    t_digit_state       ds_pre;
    t_digit_state       fin_ds;
    logic [POS_W-1:0]   fin_stop;
    t_mac_req           mac_req;
    t_mac_res           mac_res;

    // a last beat needs the result register free or draining
    assign take   = i_beat.valid && (!i_beat.last || !r_out_valid || i_out_ready);
    assign finish = take && i_beat.last;
    assign o_take = take;

    assign ch       = i_beat.character;
    assign ch_space = f_is_space(ch);
    assign ch_hex   = f_is_hex(ch);
    assign ch_x     = (ch == CH_UX) || (ch == CH_LX);
    assign ch_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign ch_digit = f_char_value(ch);

    assign first_zero = ((i_number_base == BASE_AUTO) || (i_number_base == BASE_HEX)) &&
                        (ch == CH_0);
    assign first_base = (i_number_base == BASE_AUTO) ? BASE_DEC : i_number_base;
    assign first_bad  = (first_base < BASE_MIN) || (first_base > BASE_MAX);
    assign zero_base  = (r_base == BASE_AUTO) ? BASE_OCTAL : r_base;

    always_comb begin
        mac_req.digit = ch_digit;
        mac_req.acc   = r_acc;
        mac_req.neg   = r_neg;
        mac_req.over  = (r_ds == DS_OVER);
        case (r_phase) inside
            PH_SPACE, PH_FIRST: mac_req.base = first_base;
            PH_ZERO:            mac_req.base = zero_base;
            PH_PREFIX:          mac_req.base = BASE_HEX;
            default:            mac_req.base = r_base;
        endcase
    end

    tti_digit_acc u_digit_acc (
        .i_req (mac_req),
        .o_res (mac_res)
    );

    always_comb begin
        if (first_zero) begin
            first_phase = PH_ZERO;
        end else if (first_bad || mac_res.stop) begin
            first_phase = PH_DONE;
        end else begin
            first_phase = PH_DIGITS;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_SPACE: begin
                if (ch_sign) begin
                    n_phase = PH_FIRST;
                end else if (!ch_space) begin
                    n_phase = first_phase;
                end
            end
            PH_FIRST: n_phase = first_phase;
            PH_ZERO: begin
                if (ch_x) begin
                    n_phase = PH_PREFIX;
                end else begin
                    n_phase = mac_res.stop ? PH_DONE : PH_DIGITS;
                end
            end
            PH_PREFIX: begin
                n_phase = (ch_hex && !mac_res.stop) ? PH_DIGITS : PH_DONE;
            end
            PH_DIGITS: begin
                if (mac_res.stop) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: n_phase = PH_DONE;
            default: n_phase = PH_DONE;
        endcase
        // a NUL ends the string here
        if (ch == CH_NUL) begin
            n_phase = PH_DONE;
        end
    end

    // datapath update
    always_comb begin
        n_acc      = r_acc;
        n_neg      = r_neg;
        n_ds       = r_ds;
        n_base     = r_base;
        n_stop     = r_stop;
        ds_pre     = r_ds;
        take_first = 1'b0;
        take_digit = 1'b0;
        unique case (r_phase)
            PH_SPACE: begin
                if (ch == CH_MINUS) begin
                    n_neg = 1'b1;
                end else if (!ch_space && (ch != CH_PLUS)) begin
                    take_first = 1'b1;
                end
            end
            PH_FIRST: take_first = 1'b1;
            PH_ZERO: begin
                if (ch_x) begin
                    n_stop = r_pos;
                end else begin
                    // the leading zero counts as a digit
                    n_base     = zero_base;
                    n_ds       = DS_OK;
                    ds_pre     = DS_OK;
                    take_digit = 1'b1;
                end
            end
            PH_PREFIX: begin
                if (ch_hex) begin
                    n_base     = BASE_HEX;
                    take_digit = 1'b1;
                end else begin
                    // prefix without hex digit: only the zero converts
                    n_base = zero_base;
                    n_acc  = '0;
                    n_ds   = DS_OK;
                end
            end
            PH_DIGITS: take_digit = 1'b1;
            PH_DONE: take_digit = 1'b0;
            default: take_digit = 1'b0;
        endcase
        if (take_first) begin
            if (first_zero) begin
                n_base = i_number_base;
            end else begin
                n_base     = first_base;
                take_digit = !first_bad;
            end
        end
        if (take_digit) begin
            if (mac_res.stop) begin
                n_stop = r_pos;
                n_ds   = ds_pre;
            end else begin
                n_acc = mac_res.acc;
                n_ds  = mac_res.over ? DS_OVER : DS_OK;
            end
        end
    end

    assign n_pos = (r_pos < POS_MAX) ? (r_pos + POS_W'(1)) : r_pos;

    // effect of the implied NUL after the last beat
    always_comb begin
        fin_ds   = n_ds;
        fin_stop = n_stop;
        case (n_phase)
            PH_ZERO: begin
                fin_ds   = DS_OK;
                fin_stop = n_pos;
            end
            PH_PREFIX: fin_ds = DS_OK;
            PH_DIGITS: fin_stop = n_pos;
            default: fin_ds = n_ds;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_phase <= PH_SPACE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_ds    <= DS_NONE;
            r_base  <= BASE_AUTO;
            r_pos   <= '0;
            r_stop  <= '0;
        end else if (take) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_ds    <= n_ds;
            r_base  <= n_base;
            r_pos   <= n_pos;
            r_stop  <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= finish || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_res_ds   <= fin_ds;
            r_res_neg  <= n_neg;
            r_res_acc  <= n_acc;
            r_res_stop <= fin_stop;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        case (r_res_ds)
            DS_OVER: begin
                o_value     = r_res_neg ? NEG_LIMIT : POS_LIMIT;
                o_status    = ST_RANGE;
                o_end_index = END_W'(r_res_stop);
            end
            DS_OK: begin
                o_value     = r_res_neg ? (-r_res_acc) : r_res_acc;
                o_status    = ST_OK;
                o_end_index = END_W'(r_res_stop);
            end
            default: begin
                o_value     = '0;
                o_status    = ST_INVALID;
                o_end_index = '0;
            end
        endcase
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_phase == PH_SPACE) && (r_pos == '0) && (r_ds == DS_NONE))
        else $error("parse state not cleared after last beat");

    a_over_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ds == DS_OVER) |-> ((r_phase == PH_DIGITS) || (r_phase == PH_DONE)))
        else $error("overflow flagged outside digit phase");

    a_digit_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIGITS) |-> ((r_base >= BASE_MIN) && (r_base <= BASE_MAX)))
        else $error("digit phase with illegal base");

    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= POS_MAX) && (r_stop <= r_pos))
        else $error("position out of range");

endmodule
